// ===== rtl/lba_pkg.sv =====
// Shared constants and types for the LIFO block allocator.
package lba_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned IdW       = $clog2(MaxBlocks);
  localparam int unsigned CntW      = IdW + 1;

  localparam logic [CntW-1:0] CapMax   = CntW'(MaxBlocks);
  localparam logic [CntW-1:0] CapReset = CntW'(1024);

  // Operation codes carried in the input tuser bit
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic load;    // move finished result into the output register
  } lba_cmd_t;

endpackage

// ===== rtl/lba_ctrl.sv =====
// Controller state machine: sequences accept, result assembly and output load.
module lba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lba_pkg::lba_cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StXfer
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // Output slot is free when empty or drained this cycle
  assign slot_free    = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = (state_q == StIdle) && in_valid_i;
  assign cmd_o.load   = (state_q == StXfer) && slot_free;

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StXfer;
        end
      end
      StXfer: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/lba_dpath.sv =====
// Datapath: freed-id stack memory, depth and fresh watermark, result register.
module lba_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lba_pkg::lba_cmd_t          cmd_i,
  input  logic                       func_i,
  input  logic [lba_pkg::IdW-1:0]    ret_id_i,
  input  logic                       cfg_we_i,
  input  logic [lba_pkg::CntW-1:0]   cfg_wdata_i,
  output logic [lba_pkg::IdW-1:0]    granted_id_o,
  output logic                       exhausted_o,
  output logic                       bad_id_o,
  output logic [lba_pkg::CntW-1:0]   free_blocks_o
);

  localparam int unsigned IdW  = lba_pkg::IdW;
  localparam int unsigned CntW = lba_pkg::CntW;

  logic [IdW-1:0]  stack_mem [lba_pkg::MaxBlocks];
  logic [IdW-1:0]  rd_data_q;
  logic [CntW-1:0] cap_q, depth_q, depth_d, fresh_q, fresh_d;
  logic [IdW-1:0]  gnt_q, gnt_d;
  logic            exh_q, exh_d, bad_q, bad_d, pop_q, pop_d;
  logic            push;
  logic [CntW:0]   free_sum;
  logic [CntW-1:0] free_cnt;
  logic [CntW-1:0] depth_dec;

  // Free count = stacked ids plus never-used ids
  assign free_sum  = {1'b0, depth_q} + {1'b0, cap_q} - {1'b0, fresh_q};
  assign free_cnt  = free_sum[CntW-1:0];
  assign depth_dec = depth_q - CntW'(1);

  // Operation decode at accept
  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    gnt_d   = gnt_q;
    exh_d   = exh_q;
    bad_d   = bad_q;
    pop_d   = pop_q;
    push    = 1'b0;
    if (cmd_i.accept) begin
      gnt_d = '0;
      exh_d = 1'b0;
      bad_d = 1'b0;
      pop_d = 1'b0;
      if (func_i == lba_pkg::FuncAlloc) begin
        if (depth_q != '0) begin
          depth_d = depth_dec;
          pop_d   = 1'b1;
        end else if (fresh_q < cap_q) begin
          gnt_d   = fresh_q[IdW-1:0];
          fresh_d = fresh_q + CntW'(1);
        end else begin
          exh_d = 1'b1;
        end
      end else begin
        if ({1'b0, ret_id_i} >= cap_q) begin
          bad_d = 1'b1;
        end else if (free_cnt < cap_q && depth_q < lba_pkg::CapMax) begin
          push    = 1'b1;
          depth_d = depth_q + CntW'(1);
        end
      end
    end
  end

  // Stack memory: a write for each pushed free and a registered read at every accept;
  // the popped entry is held until the result is loaded
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[depth_q[IdW-1:0]] <= ret_id_i;
    end
    if (cmd_i.accept) begin
      rd_data_q <= stack_mem[depth_dec[IdW-1:0]];
    end
  end

  // Pool state; a capacity write reinitializes the pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= lba_pkg::CapReset;
      depth_q <= '0;
      fresh_q <= '0;
      gnt_q   <= '0;
      exh_q   <= 1'b0;
      bad_q   <= 1'b0;
      pop_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= (cfg_wdata_i > lba_pkg::CapMax) ? lba_pkg::CapMax : cfg_wdata_i;
        depth_q <= '0;
        fresh_q <= '0;
      end else begin
        depth_q <= depth_d;
        fresh_q <= fresh_d;
      end
      gnt_q <= gnt_d;
      exh_q <= exh_d;
      bad_q <= bad_d;
      pop_q <= pop_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      granted_id_o  <= pop_q ? rd_data_q : gnt_q;
      exhausted_o   <= exh_q;
      bad_id_o      <= bad_q;
      free_blocks_o <= free_cnt;
    end
  end

endmodule

// ===== rtl/lifo_block_allocator_core.sv =====
// Top level of the LIFO free-list block allocator.
//
// Channel   Dir  Width  Contents
// s_axis    in   16+1   tdata: ret_id; tuser: func (0 allocate, 1 free)
// m_axis    out  24     tdata: granted_id, exhausted, bad_id, free_blocks
// cfg       in   11     pool_capacity write, reinitializes the pool
//
// Each transaction is accepted, then the freed-id stack memory is read into a
// register before the result is loaded.
// The next transaction is taken while a result waits in the output register.
// Reset clears the pool (capacity 1024, nothing stacked, watermark at 0).
// A stalled output holds the block in its transfer state until the slot drains.
module lifo_block_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [9:0] ret_id
  input  logic                        s_axis_tuser,  // [0] func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [9:0] granted_id, [10] exhausted, [11] bad_id, [22:12] free_blocks
  output logic [23:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [lba_pkg::CntW-1:0]    cfg_wdata_i
);

  lba_pkg::lba_cmd_t            cmd;
  logic [lba_pkg::IdW-1:0]      granted_id;
  logic                         exhausted;
  logic                         bad_id;
  logic [lba_pkg::CntW-1:0]     free_blocks;

  lba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lba_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (s_axis_tuser),
    .ret_id_i      (s_axis_tdata[lba_pkg::IdW-1:0]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .granted_id_o  (granted_id),
    .exhausted_o   (exhausted),
    .bad_id_o      (bad_id),
    .free_blocks_o (free_blocks)
  );

  assign m_axis_tdata = {1'b0, free_blocks, bad_id, exhausted, granted_id};

  // One transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accept while previous transaction still in progress");

  // An exhausted allocate grants nothing and is never a bad free
  a_exhausted_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[10]) |-> (m_axis_tdata[9:0] == '0 && !m_axis_tdata[11]))
    else $error("exhausted result carries an id or bad flag");

  // Free count never exceeds the maximum pool capacity
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22:12] <= lba_pkg::CapMax))
    else $error("free block count above pool size");

  // Result appears only after an accepted transaction
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a transaction in progress");

endmodule
